// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define MH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define MH_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/mh64_pkg.sv =====
// ----------------------------------------------------------------------------
// mh64_pkg
// constants, types and helpers shared by the 64-bit murmur hash block
// ----------------------------------------------------------------------------
package mh64_pkg;

   localparam logic [63:0] MIX_MULT    = 64'hc6a4a7935bd1e995;
   localparam int          MIX_SHIFT   = 47;
   localparam logic [63:0] SEED_RESET  = 64'd76493;

   localparam int          CSR_ADDR_WIDTH = 4;
   localparam logic [CSR_ADDR_WIDTH-1:0] SEED_ADDR = 4'h0;

   // request to the shared multiplier: operand is multiplied by MIX_MULT
   typedef struct packed {
      logic        start;
      logic [63:0] operand;
   } mul_req_type;

   // response from the shared multiplier, product valid from done onward
   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

   // low n bytes set, n from 0 to 7
   function automatic logic [63:0] byte_mask(input logic [2:0] n);
      logic [63:0] mask;
      mask = '0;
      for (int i = 0; i < 8; i++) begin
         if (3'(i) < n) begin
            mask[8*i +: 8] = 8'hff;
         end
      end
      return mask;
   endfunction

   // x ^ (x >> 47)
   function automatic logic [63:0] shift_xor(input logic [63:0] x);
      return x ^ (x >> MIX_SHIFT);
   endfunction

endpackage

// ===== rtl/mh64_mul.sv =====
// ----------------------------------------------------------------------------
// mh64_mul
// shared multiply-by-constant unit, 64 x 64 mod 2^64 on one 32 x 32 multiplier
// ----------------------------------------------------------------------------
module mh64_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  mh64_pkg::mul_req_type mul_req,
   output mh64_pkg::mul_rsp_type mul_rsp
);

   logic [63:0] op_ff, op_in;
   logic [63:0] prod_ff;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic [31:0] mult_a;
   logic [31:0] mult_b;
   logic [63:0] prod_in;

   // step 0: lo*lo, step 1: hi*lo, step 2: lo*hi; cross terms only need low 32 bits
   assign mult_a  = (step_ff == 2'd1) ? op_ff[63:32] : op_ff[31:0];
   assign mult_b  = (step_ff == 2'd2) ? mh64_pkg::MIX_MULT[63:32]
                                      : mh64_pkg::MIX_MULT[31:0];
   assign prod_in = {32'b0, mult_a} * {32'b0, mult_b};

   always_comb begin
      op_in   = op_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         op_in   = mul_req.operand;
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff + 2'd1;
         unique case (step_ff)
            2'd0: begin
            end
            2'd1: begin
               acc_in = prod_ff;
            end
            2'd2: begin
               acc_in[63:32] = acc_ff[63:32] + prod_ff[31:0];
            end
            default: begin
               acc_in[63:32] = acc_ff[63:32] + prod_ff[31:0];
               busy_in       = 1'b0;
               done_in       = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

// ===== rtl/mh64_seq.sv =====
// ----------------------------------------------------------------------------
// mh64_seq
// message sequencer: seeding, word mixing, tail fold, avalanche and result
// ----------------------------------------------------------------------------
module mh64_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [63:0]           seed,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [103:0]          req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,
   output mh64_pkg::mul_req_type mul_req,
   input  mh64_pkg::mul_rsp_type mul_rsp
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_DISPATCH,
      ST_MIX1,
      ST_MIX2,
      ST_FOLD,
      ST_FINISH,
      ST_AVAL,
      ST_EMIT
   } state_type;

   state_type   state_ff, state_in;
   logic [63:0] hash_ff, hash_in;
   logic [63:0] word_ff, word_in;
   logic [3:0]  count_ff, count_in;
   logic        last_ff, last_in;
   logic        start_ff, start_in;
   logic [63:0] operand_ff, operand_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   logic        accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      word_in      = word_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      start_in     = 1'b0;
      operand_in   = operand_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               word_in  = req_tdata[63:0];
               count_in = req_tdata[67:64];
               last_in  = req_tlast;
               if (req_tuser) begin
                  // length times multiplier, length is zero extended
                  start_in   = 1'b1;
                  operand_in = {33'b0, req_tdata[98:68]};
                  state_in   = ST_SEED;
               end else begin
                  state_in = ST_DISPATCH;
               end
            end
         end
         ST_SEED: begin
            if (mul_rsp.done) begin
               hash_in  = seed ^ mul_rsp.product;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (count_ff[3]) begin
               start_in   = 1'b1;
               operand_in = word_ff;
               state_in   = ST_MIX1;
            end else if (count_ff[2:0] != 3'd0) begin
               start_in   = 1'b1;
               operand_in = hash_ff ^ (word_ff & mh64_pkg::byte_mask(count_ff[2:0]));
               state_in   = ST_FOLD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MIX1: begin
            if (mul_rsp.done) begin
               start_in   = 1'b1;
               operand_in = mh64_pkg::shift_xor(mul_rsp.product);
               state_in   = ST_MIX2;
            end
         end
         ST_MIX2: begin
            if (mul_rsp.done) begin
               start_in   = 1'b1;
               operand_in = hash_ff ^ mul_rsp.product;
               state_in   = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (mul_rsp.done) begin
               hash_in  = mul_rsp.product;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (last_ff) begin
               start_in   = 1'b1;
               operand_in = mh64_pkg::shift_xor(hash_ff);
               state_in   = ST_AVAL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_AVAL: begin
            if (mul_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // product holds until the next start
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mh64_pkg::shift_xor(mul_rsp.product);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff     <= word_in;
      count_ff    <= count_in;
      last_ff     <= last_in;
      operand_ff  <= operand_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign mul_req.start   = start_ff;
   assign mul_req.operand = operand_ff;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

endmodule

// ===== rtl/murmur_hash_64a.sv =====
// ----------------------------------------------------------------------------
// murmur_hash_64a
// streaming 64-bit murmur hash (64a variant) with an apb seed register
// ----------------------------------------------------------------------------
// one transaction at a time; each 64-bit multiply holds the sequencer through the
// operand register, three partial products, the fold and the done register
// a full word takes three multiplies, a tail word one, a zero-count word none
// a first word adds one for seeding, a last word adds one for the avalanche and
// the result register, which waits while an earlier hash still waits on rsp_tready
// reset: synchronous, clears the sequencer, running hash to zero, seed to 76493
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module murmur_hash_64a (
   input  logic         clock,
   input  logic         reset,
   // input stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // data_word[63:0], byte_count[67:64],
                                     // total_length[98:68], zero pad
   input  logic         req_tuser,   // first
   input  logic         req_tlast,   // last
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // hash_value[63:0]
   // configuration port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   logic [63:0]           seed_ff, seed_in;
   logic                  csr_write;
   logic                  seed_sel;
   mh64_pkg::mul_req_type mul_req;
   mh64_pkg::mul_rsp_type mul_rsp;

   // ---------------------------------------------------------------------
   // seed register, written on the apb access phase, zero wait states
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign seed_sel   = (csr_paddr == mh64_pkg::SEED_ADDR);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      seed_in = seed_ff;
      if (csr_write && seed_sel) begin
         seed_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= mh64_pkg::SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // unmapped addresses read as zero
   assign csr_prdata = seed_sel ? seed_ff : 64'd0;

   // ---------------------------------------------------------------------
   // sequencer: owns the running hash and the result register
   // ---------------------------------------------------------------------
   mh64_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .seed       (seed_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mul_req    (mul_req),
      .mul_rsp    (mul_rsp)
   );

   // ---------------------------------------------------------------------
   // shared multiply-by-constant unit
   // ---------------------------------------------------------------------
   mh64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // the multiplier is only started while a transaction is in flight
   `MH_ASSERT_IMP(a_start_busy, clock, reset, mul_req.start, !req_tready)
   // a multiply finishes only while a transaction is in flight
   `MH_ASSERT_IMP(a_done_busy, clock, reset, mul_rsp.done, !req_tready)
   // done is a single-cycle pulse
   `MH_ASSERT_NXT(a_done_pulse, clock, reset, mul_rsp.done, !mul_rsp.done)

endmodule

// ===== dv/tb_murmur_hash_64a.sv =====
// ----------------------------------------------------------------------------
// tb_murmur_hash_64a
// self-checking bench for the streaming 64-bit murmur hash (64a variant)
// an initial block queues messages for a clocked driver, a clocked monitor
// pops the predicted hashes in order and compares each result against them
// the seed register is reprogrammed between phases while the block is idle
// ----------------------------------------------------------------------------
module tb_murmur_hash_64a;

   // cycles with no transaction on either stream before the run is abandoned
   localparam int STALL_LIMIT   = 4000;
   // worst-case work per request is seeding + full word + avalanche
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASE_ITEMS   = 275;

   // one request beat as the sender sees it
   typedef struct {
      logic [63:0] word;
      logic [3:0]  count;
      logic [30:0] length;
      logic        first;
      logic        last;
      bit          drain_first;   // hold until every pending hash has come back
   } msg_item_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid  = 1'b0;
   wire          req_tready;
   logic [103:0] req_tdata   = '0;   // data_word, byte_count, total_length, pad
   logic         req_tuser   = 1'b0; // first
   logic         req_tlast   = 1'b0; // last
   wire          rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   wire  [63:0]  rsp_tdata;          // hash_value
   logic         csr_psel    = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite  = 1'b0;
   logic [mh64_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [63:0]  csr_pwdata  = '0;
   wire  [63:0]  csr_prdata;
   wire          csr_pready;

   // predictor state, mirrors the block's seed register and running hash
   logic [63:0]  hash_seed  = mh64_pkg::SEED_RESET;
   logic [63:0]  hash_state = '0;

   msg_item_type pending_items[$];
   logic [63:0]  expected_hashes[$];
   msg_item_type offered_item;
   int unsigned  queued_count = 0;
   int unsigned  mismatches   = 0;
   int unsigned  idle_cycles  = 0;
   bit           no_gaps      = 1'b0;

   murmur_hash_64a u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // hash predictor
   // ---------------------------------------------------------------------------

   // fold one accepted request into the running hash; a last beat finalizes
   function automatic void absorb_item(input msg_item_type it);
      logic [63:0] h;
      logic [63:0] k;
      logic [63:0] mask;
      h = hash_state;
      // a first beat reseeds before its own word is mixed in
      if (it.first) begin
         h = hash_seed ^ (64'(it.length) * mh64_pkg::MIX_MULT);
      end
      // counts of eight and up behave as a full word
      if (it.count >= 4'd8) begin
         k = it.word * mh64_pkg::MIX_MULT;
         k = k ^ (k >> mh64_pkg::MIX_SHIFT);
         k = k * mh64_pkg::MIX_MULT;
         h = (h ^ k) * mh64_pkg::MIX_MULT;
      end else if (it.count != 4'd0) begin
         // partial word: only the low bytes enter, then one multiply
         mask = (64'd1 << (8 * it.count)) - 64'd1;
         h = (h ^ (it.word & mask)) * mh64_pkg::MIX_MULT;
      end
      // the unfinalized value carries over, even past a last beat
      hash_state = h;
      if (it.last) begin
         h = h ^ (h >> mh64_pkg::MIX_SHIFT);
         h = h * mh64_pkg::MIX_MULT;
         h = h ^ (h >> mh64_pkg::MIX_SHIFT);
         expected_hashes.push_back(h);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at %0t: %s, got %h expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------------
   // stimulus builders
   // ---------------------------------------------------------------------------

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic push_item(input logic [63:0] word, input logic [3:0] count,
                            input logic [30:0] length, input logic first,
                            input logic last, input bit drain_first = 1'b0);
      msg_item_type it;
      it.word        = word;
      it.count       = count;
      it.length      = length;
      it.first       = first;
      it.last        = last;
      it.drain_first = drain_first;
      pending_items.push_back(it);
      queued_count++;
   endtask

   // well-formed message of len bytes; closed = 0 drops the closing last flag,
   // length_field lets the header disagree with the real byte count
   task automatic queue_message(input int unsigned len, input logic [30:0] length_field,
                                input bit closed, input bit drain_first);
      int unsigned n_words;
      int unsigned tail;
      n_words = (len == 0) ? 1 : (len + 7) / 8;
      for (int unsigned i = 0; i < n_words; i++) begin
         tail = (i == n_words - 1) ? len - 8 * i : 8;
         push_item(rand_word(), 4'(tail), length_field, i == 0,
                   closed && (i == n_words - 1), drain_first && (i == 0));
      end
   endtask

   // mostly proper messages, some broken ones, a sprinkle of raw noise beats
   task automatic queue_random_phase(input int unsigned n_items);
      int unsigned target;
      int unsigned roll;
      int unsigned len_roll;
      int unsigned len;
      logic [30:0] length_field;
      target = queued_count + n_items;
      while (queued_count < target) begin
         roll     = $urandom_range(99);
         len_roll = $urandom_range(99);
         if (len_roll < 70) begin
            len = $urandom_range(24);
         end else if (len_roll < 96) begin
            len = $urandom_range(96, 25);
         end else begin
            len = $urandom_range(400, 97);
         end
         // header length usually matches, occasionally anything in range
         length_field = ($urandom_range(9) == 0) ? 31'($urandom) : 31'(len);
         if (roll < 78) begin
            queue_message(len, length_field, 1'b1, $urandom_range(59) == 0);
         end else if (roll < 88) begin
            // message that never closes; the next first beat reseeds
            queue_message(len, length_field, 1'b0, 1'b0);
         end else begin
            push_item(rand_word(), 4'($urandom_range(15)), 31'($urandom),
                      1'($urandom), 1'($urandom));
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // phase control
   // ---------------------------------------------------------------------------

   // sender drained, every hash returned, then room for any trailing work
   task automatic wait_for_idle();
      @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_hashes.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup then access cycle; the register takes the value at the access edge
   task automatic write_seed(input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= mh64_pkg::SEED_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      hash_seed = value;
   endtask

   initial begin
      logic [63:0] phase_seeds[6];
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part, runs on the reset seed
      // word before any message: continues from the cleared running hash
      push_item(rand_word(), 4'd8, 31'd0, 1'b0, 1'b1);
      // empty message
      push_item(64'h0, 4'd0, 31'd0, 1'b1, 1'b1);
      // full single-word messages at both data extremes
      push_item('1, 4'd8, 31'd8, 1'b1, 1'b1);
      push_item('0, 4'd8, 31'd8, 1'b1, 1'b1);
      // every tail size, all-ones data so the byte mask shows
      for (int n = 1; n < 8; n++) begin
         push_item('1, 4'(n), 31'(n), 1'b1, 1'b1);
      end
      // oversized count with the longest header length
      push_item(rand_word(), 4'd12, 31'h7fff_ffff, 1'b1, 1'b1);
      // short word in mid message, then the message carries on
      push_item('1, 4'd3, 31'd16, 1'b1, 1'b0);
      push_item(rand_word(), 4'd15, 31'd0, 1'b0, 1'b0);
      push_item(rand_word(), 4'd5, 31'd0, 1'b0, 1'b1);
      // keeps going after a last beat without reseeding
      push_item(rand_word(), 4'd8, 31'd0, 1'b0, 1'b1);
      // header length disagrees with the words that follow
      push_item(rand_word(), 4'd2, 31'd100, 1'b1, 1'b1);
      // zero-count beat mid message changes nothing
      push_item(rand_word(), 4'd8, 31'd9, 1'b1, 1'b0);
      push_item(rand_word(), 4'd0, 31'h5555_5555, 1'b0, 1'b0);
      push_item(rand_word(), 4'd1, 31'h2aaa_aaaa, 1'b0, 1'b1);
      wait_for_idle();

      // random phases across seed extremes and random seeds
      phase_seeds[0] = 64'h0;
      phase_seeds[1] = '1;
      phase_seeds[2] = 64'h8000_0000_0000_0000;
      phase_seeds[3] = rand_word();
      phase_seeds[4] = rand_word();
      phase_seeds[5] = mh64_pkg::SEED_RESET;
      for (int p = 0; p < 6; p++) begin
         write_seed(phase_seeds[p]);
         // one phase runs with both sides never stalling
         @(negedge clock);
         no_gaps = (p == 1);
         queue_random_phase(PHASE_ITEMS);
         wait_for_idle();
      end

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // request driver: one nonblocking update of valid per edge
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      logic take;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // transaction completes at this edge
         if (req_tvalid && req_tready) begin
            absorb_item(offered_item);
         end
         if (!req_tvalid || req_tready) begin
            take = pending_items.size() != 0 && (no_gaps || $urandom_range(99) >= 14);
            // hold-off: wait for the result stream to drain completely
            if (take && pending_items[0].drain_first && expected_hashes.size() != 0) begin
               take = 1'b0;
            end
            if (take) begin
               offered_item = pending_items.pop_front();
               req_tdata  <= {5'b0, offered_item.length, offered_item.count, offered_item.word};
               req_tuser  <= offered_item.first;
               req_tlast  <= offered_item.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // result monitor: in-order compare against the predicted hashes
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      logic [63:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hashes.size() == 0) begin
               report_mismatch("hash with none pending", rsp_tdata, '0);
            end else begin
               want = expected_hashes.pop_front();
               if (rsp_tdata !== want) begin
                  report_mismatch("hash_value", rsp_tdata, want);
               end
            end
         end
         rsp_tready <= no_gaps || $urandom_range(99) >= 14;
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: too long without a transaction on either stream
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
